FILE: rtl/core/assert_macros.svh
// shared assertion shorthands for the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/core/sfq_pkg.sv
package sfq_pkg;

    localparam int SFQ_QUEUE_DEPTH = 8;
    localparam int MAX_RESULTS     = 8;
    localparam int RES_IDX_W       = 3;
    localparam int RES_CNT_W       = 4;

    localparam int ADDR_W  = 48;
    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 4;
    localparam int SLOT_W  = 3;
    localparam int COUNT_W = 4;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    localparam logic [ADDR_W-1:0]  OWN_ADDR_RESET    = '0;
    localparam logic [TIME_W-1:0]  EXPIRE_RESET      = 32'd300000;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd3;

    // register index, taken from paddr[4:3]
    localparam logic [1:0] REG_OWN_ADDR    = 2'd0;
    localparam logic [1:0] REG_EXPIRE_MS   = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_ACK     = 2'd1,
        OP_DELIVER = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } sfq_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  target;
        logic [ID_W-1:0]    msg_id;
        logic [TIME_W-1:0]  stamp;
        logic [RETRY_W-1:0] retries;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [ID_W-1:0]   entry_id;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  own_address;
        logic [TIME_W-1:0]  expire_ms;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        entry_t            entry;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] otime;
        logic [TIME_W-1:0] expire;
    } cmp_req_t;

endpackage

FILE: rtl/core/sfq_cmd_if.sv
interface sfq_cmd_if import sfq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] peer_addr;
    logic [ID_W-1:0]   message_id;
    logic [TIME_W-1:0] now_ms;
    logic              send_ok;

    modport source (
        output valid, opcode, peer_addr, message_id, now_ms, send_ok,
        input  ready
    );

    modport sink (
        input  valid, opcode, peer_addr, message_id, now_ms, send_ok,
        output ready
    );
endinterface

FILE: rtl/core/sfq_res_if.sv
interface sfq_res_if import sfq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [ID_W-1:0]    entry_id;
    logic [COUNT_W-1:0] expired_count;
    logic [COUNT_W-1:0] live_count;
    logic               last;

    modport source (
        output valid, hit, slot, evicted, entry_id, expired_count, live_count, last,
        input  ready
    );

    modport sink (
        input  valid, hit, slot, evicted, entry_id, expired_count, live_count, last,
        output ready
    );
endinterface

FILE: rtl/core/store_forward_queue_unit.sv
// store-and-forward message queue with oldest-entry replacement
// cmd channel: one word per operation (store, ack, deliver, expiry tick);
// res channel: one or more result words per operation, the final one
// carrying last. every result word reports the live count after the
// whole operation.
// an operation scans all QUEUE_DEPTH slots through the single read port
// of the entry ram, one slot per cycle, with one shared compare unit,
// then emits its result words (deliver up to 8, the others exactly one).
// cmd ready is high only while idle, so one operation is in flight; the
// next command can be taken in the cycle after the last result word is
// accepted.
// reset clears the valid bits and the live count; entry payloads stay
// undefined until stored. configuration resets to own_address 0,
// expire_ms 300000, retry_limit 3.
// if the receiver holds res ready low, the current result word stays
// on the port unchanged and no new command is taken until the last
// result word has been accepted.
`include "assert_macros.svh"

module store_forward_queue_unit import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = SFQ_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    sfq_cmd_if.sink            cmd,
    sfq_res_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cfg_t cfg;

    sfq_state_t state_reg, state_next;

    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              ok_reg, ok_next;
    logic              own_match_reg, own_match_next;

    logic [CNT_W-1:0]       scan_reg, scan_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       eval_reg, eval_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       live_reg, live_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       oldest_reg, oldest_next;
    logic [TIME_W-1:0]      otime_reg, otime_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       expc_reg, expc_next;
    logic [RES_CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic [RES_IDX_W-1:0]   emit_reg, emit_next;

    res_t                 res_buf_reg [MAX_RESULTS];
    logic                 buf_we;
    logic [RES_IDX_W-1:0] buf_idx;
    res_t                 buf_data;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    cmp_req_t             cmp_req;
    logic                 cmp_match;
    logic                 ev_valid;
    logic [RETRY_W-1:0]   retries_new;
    logic                 retire;
    logic [IDX_W-1:0]     store_slot;
    res_t                 cur_res;
    logic                 is_last;

    sfq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    assign cmp_req.op     = op_reg;
    assign cmp_req.entry  = rd_entry;
    assign cmp_req.addr   = addr_reg;
    assign cmp_req.id     = id_reg;
    assign cmp_req.now    = now_reg;
    assign cmp_req.otime  = otime_reg;
    assign cmp_req.expire = cfg.expire_ms;

    sfq_cmp_unit u_cmp (
        .req   (cmp_req),
        .match (cmp_match)
    );

    assign ev_valid    = valid_reg[eval_reg];
    assign retries_new = (rd_entry.retries == RETRY_MAX) ? RETRY_MAX
                                                         : rd_entry.retries + 1'b1;
    assign retire      = ok_reg && (retries_new >= cfg.retry_limit);
    assign store_slot  = free_found_reg ? free_idx_reg : oldest_reg;

    assign cur_res = res_buf_reg[emit_reg];
    assign is_last = (RES_CNT_W'(emit_reg) + 1'b1) == res_cnt_reg;

    assign res.hit           = cur_res.hit;
    assign res.slot          = cur_res.slot;
    assign res.evicted       = cur_res.evicted;
    assign res.entry_id      = cur_res.entry_id;
    assign res.expired_count = (op_reg == OP_TICK) ? COUNT_W'(expc_reg) : '0;
    assign res.live_count    = COUNT_W'(live_reg);
    assign res.last          = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            eval_reg       <= '0;
            valid_reg      <= '0;
            live_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            oldest_reg     <= '0;
            otime_reg      <= '1;
            found_reg      <= 1'b0;
            expc_reg       <= '0;
            res_cnt_reg    <= '0;
            emit_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            pend_reg       <= pend_next;
            eval_reg       <= eval_next;
            valid_reg      <= valid_next;
            live_reg       <= live_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            oldest_reg     <= oldest_next;
            otime_reg      <= otime_next;
            found_reg      <= found_next;
            expc_reg       <= expc_next;
            res_cnt_reg    <= res_cnt_next;
            emit_reg       <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        id_reg        <= id_next;
        now_reg       <= now_next;
        ok_reg        <= ok_next;
        own_match_reg <= own_match_next;
        if (buf_we)
        begin
            res_buf_reg[buf_idx] <= buf_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        ok_next         = ok_reg;
        own_match_next  = own_match_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        eval_next       = eval_reg;
        valid_next      = valid_reg;
        live_next       = live_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        oldest_next     = oldest_reg;
        otime_next      = otime_reg;
        found_next      = found_reg;
        expc_next       = expc_reg;
        res_cnt_next    = res_cnt_reg;
        emit_next       = emit_reg;

        buf_we    = 1'b0;
        buf_idx   = '0;
        buf_data  = '0;
        ram_we    = 1'b0;
        ram_waddr = eval_reg;
        ram_wdata = rd_entry;
        ram_raddr = scan_reg[IDX_W-1:0];

        cmd.ready = 1'b0;
        res.valid = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    op_next         = op_t'(cmd.opcode);
                    addr_next       = cmd.peer_addr;
                    id_next         = cmd.message_id;
                    now_next        = cmd.now_ms;
                    ok_next         = cmd.send_ok;
                    own_match_next  = (cmd.peer_addr == cfg.own_address);
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    oldest_next     = '0;
                    otime_next      = '1;
                    found_next      = 1'b0;
                    expc_next       = '0;
                    res_cnt_next    = '0;
                    emit_next       = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read of the next slot overlaps the evaluation of the previous one
                if (scan_reg != DEPTH_CNT)
                begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                    eval_next = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    unique case (op_reg)
                        OP_STORE:
                        begin
                            if (!ev_valid)
                            begin
                                if (!free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = eval_reg;
                                end
                            end
                            else if (cmp_match)
                            begin
                                otime_next  = rd_entry.stamp;
                                oldest_next = eval_reg;
                            end
                        end
                        OP_ACK:
                        begin
                            if (own_match_reg && !found_reg && ev_valid && cmp_match)
                            begin
                                valid_next[eval_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                                found_next           = 1'b1;
                                buf_we               = 1'b1;
                                buf_idx              = '0;
                                buf_data.hit         = 1'b1;
                                buf_data.slot        = SLOT_W'(eval_reg);
                                buf_data.evicted     = 1'b0;
                                buf_data.entry_id    = rd_entry.msg_id;
                            end
                        end
                        OP_DELIVER:
                        begin
                            if (ev_valid && cmp_match)
                            begin
                                if (ok_reg)
                                begin
                                    ram_we            = 1'b1;
                                    ram_wdata.retries = retries_new;
                                end
                                if (retire)
                                begin
                                    valid_next[eval_reg] = 1'b0;
                                    live_next            = live_reg - 1'b1;
                                end
                                // only the first eight deliveries are reported
                                if (res_cnt_reg < RES_CNT_W'(MAX_RESULTS))
                                begin
                                    buf_we            = 1'b1;
                                    buf_idx           = res_cnt_reg[RES_IDX_W-1:0];
                                    buf_data.hit      = 1'b1;
                                    buf_data.slot     = SLOT_W'(eval_reg);
                                    buf_data.evicted  = retire;
                                    buf_data.entry_id = rd_entry.msg_id;
                                    res_cnt_next      = res_cnt_reg + 1'b1;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (ev_valid && cmp_match)
                            begin
                                valid_next[eval_reg] = 1'b0;
                                live_next            = live_reg - 1'b1;
                                expc_next            = expc_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                else if (scan_reg == DEPTH_CNT)
                begin
                    state_next   = ST_EMIT;
                    res_cnt_next = RES_CNT_W'(1);
                    unique case (op_reg)
                        OP_STORE:
                        begin
                            ram_we                 = 1'b1;
                            ram_waddr              = store_slot;
                            ram_wdata.target       = addr_reg;
                            ram_wdata.msg_id       = id_reg;
                            ram_wdata.stamp        = now_reg;
                            ram_wdata.retries      = '0;
                            valid_next[store_slot] = 1'b1;
                            if (free_found_reg)
                            begin
                                live_next = live_reg + 1'b1;
                            end
                            buf_we            = 1'b1;
                            buf_data.hit      = 1'b1;
                            buf_data.slot     = SLOT_W'(store_slot);
                            buf_data.evicted  = !free_found_reg;
                            buf_data.entry_id = id_reg;
                        end
                        OP_ACK:
                        begin
                            buf_we = !found_reg;
                        end
                        OP_DELIVER:
                        begin
                            if (res_cnt_reg != '0)
                            begin
                                res_cnt_next = res_cnt_reg;
                            end
                            else
                            begin
                                buf_we = 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            buf_we = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            ST_EMIT:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_HOLDS(a_live_matches_valid, clk, rst_n, $countones(valid_reg) == int'(live_reg))
    `ASSERT_HOLDS(a_live_bounded, clk, rst_n, live_reg <= DEPTH_CNT)
    `ASSERT_IMPLIES(a_no_accept_while_emit, clk, rst_n, res.valid, !cmd.ready)
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, res.valid && res.ready && res.last, state_reg == ST_IDLE)

endmodule

FILE: rtl/core/sfq_ram.sv
module sfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/sfq_cfg_regs.sv
module sfq_cfg_regs import sfq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address <= OWN_ADDR_RESET;
            cfg_reg.expire_ms   <= EXPIRE_RESET;
            cfg_reg.retry_limit <= RETRY_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OWN_ADDR:    cfg_reg.own_address <= pwdata[ADDR_W-1:0];
                REG_EXPIRE_MS:   cfg_reg.expire_ms   <= pwdata[TIME_W-1:0];
                REG_RETRY_LIMIT: cfg_reg.retry_limit <= pwdata[RETRY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OWN_ADDR:    prdata = PDATA_W'(cfg_reg.own_address);
            REG_EXPIRE_MS:   prdata = PDATA_W'(cfg_reg.expire_ms);
            REG_RETRY_LIMIT: prdata = PDATA_W'(cfg_reg.retry_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/sfq_cmp_unit.sv
module sfq_cmp_unit import sfq_pkg::*; (
    input  cmp_req_t req,
    output logic     match
);

    logic [ADDR_W-1:0] opa;
    logic [ADDR_W-1:0] opb;
    logic              use_eq;
    logic [TIME_W-1:0] age;

    // wrapping age of the entry
    assign age = req.now - req.entry.stamp;

    always_comb
    begin
        unique case (req.op)
            OP_STORE:
            begin
                opa    = ADDR_W'(req.entry.stamp);
                opb    = ADDR_W'(req.otime);
                use_eq = 1'b0;
            end
            OP_ACK:
            begin
                opa    = ADDR_W'(req.entry.msg_id);
                opb    = ADDR_W'(req.id);
                use_eq = 1'b1;
            end
            OP_DELIVER:
            begin
                opa    = req.entry.target;
                opb    = req.addr;
                use_eq = 1'b1;
            end
            OP_TICK:
            begin
                opa    = ADDR_W'(req.expire);
                opb    = ADDR_W'(age);
                use_eq = 1'b0;
            end
            default:
            begin
                opa    = '0;
                opb    = '0;
                use_eq = 1'b1;
            end
        endcase
        match = use_eq ? (opa == opb) : (opa < opb);
    end

endmodule

FILE: tb/sfq_result_checker.sv
module sfq_result_checker import sfq_pkg::*; #(
    parameter int DEPTH = SFQ_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    sfq_cmd_if                 cmd,
    sfq_res_if                 res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatches,
    output int                 words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [ID_W-1:0]    entry_id;
        logic [COUNT_W-1:0] expired_count;
        logic [COUNT_W-1:0] live_count;
        logic               last;
    } result_word_t;

    // shadow of the message table and the registers
    bit                 tbl_live   [DEPTH];
    logic [ADDR_W-1:0]  tbl_target [DEPTH];
    logic [ID_W-1:0]    tbl_id     [DEPTH];
    logic [TIME_W-1:0]  tbl_stamp  [DEPTH];
    logic [RETRY_W-1:0] tbl_tries  [DEPTH];

    logic [ADDR_W-1:0]  own_addr_cfg;
    logic [TIME_W-1:0]  expire_cfg;
    logic [RETRY_W-1:0] retry_cfg;

    result_word_t due_words[$];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_queue_op(input op_t op, input logic [ADDR_W-1:0] addr,
                                    input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] now, input logic ok);
        result_word_t words[$];
        result_word_t one;
        int pick;
        int oldest;
        int expc;
        int live;
        logic [TIME_W-1:0] otime;
        logic [TIME_W-1:0] age;
        logic retired;
        one = '0;
        case (op)
            OP_STORE:
            begin
                pick = -1;
                oldest = 0;
                otime = '1;
                for (int k = 0; k < DEPTH; k++)
                begin
                    if (pick < 0 && !tbl_live[k])
                        pick = k;
                    else if (pick < 0 && tbl_stamp[k] < otime)
                    begin
                        otime = tbl_stamp[k];
                        oldest = k;
                    end
                end
                if (pick < 0)
                    pick = oldest;
                one.hit = 1'b1;
                one.slot = pick[SLOT_W-1:0];
                one.evicted = tbl_live[pick];
                one.entry_id = id;
                tbl_live[pick] = 1'b1;
                tbl_target[pick] = addr;
                tbl_id[pick] = id;
                tbl_stamp[pick] = now;
                tbl_tries[pick] = '0;
                words = {words, one};
            end
            OP_ACK:
            begin
                pick = -1;
                if (addr == own_addr_cfg)
                    for (int k = 0; k < DEPTH; k++)
                        if (pick < 0 && tbl_live[k] && tbl_id[k] == id)
                            pick = k;
                if (pick >= 0)
                begin
                    tbl_live[pick] = 1'b0;
                    one.hit = 1'b1;
                    one.slot = pick[SLOT_W-1:0];
                    one.entry_id = tbl_id[pick];
                end
                words = {words, one};
            end
            OP_DELIVER:
            begin
                for (int k = 0; k < DEPTH; k++)
                begin
                    if (tbl_live[k] && tbl_target[k] == addr)
                    begin
                        retired = 1'b0;
                        if (ok)
                        begin
                            if (tbl_tries[k] < RETRY_MAX)
                                tbl_tries[k] = tbl_tries[k] + 1'b1;
                            if (tbl_tries[k] >= retry_cfg)
                            begin
                                tbl_live[k] = 1'b0;
                                retired = 1'b1;
                            end
                        end
                        // only the first MAX_RESULTS deliveries are reported
                        if (words.size() < MAX_RESULTS)
                        begin
                            one = '0;
                            one.hit = 1'b1;
                            one.slot = k[SLOT_W-1:0];
                            one.evicted = retired;
                            one.entry_id = tbl_id[k];
                            words = {words, one};
                        end
                    end
                end
                if (words.size() == 0)
                begin
                    one = '0;
                    words = {words, one};
                end
            end
            default:
            begin
                expc = 0;
                for (int k = 0; k < DEPTH; k++)
                begin
                    age = now - tbl_stamp[k];
                    if (tbl_live[k] && age > expire_cfg)
                    begin
                        tbl_live[k] = 1'b0;
                        expc++;
                    end
                end
                one.expired_count = expc[COUNT_W-1:0];
                words = {words, one};
            end
        endcase
        live = 0;
        for (int k = 0; k < DEPTH; k++)
            if (tbl_live[k])
                live++;
        foreach (words[i])
        begin
            words[i].live_count = live[COUNT_W-1:0];
            words[i].last = (i == words.size() - 1);
            due_words = {due_words, words[i]};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_word_t want;
        if (!rst_n)
        begin
            foreach (tbl_live[k])
                tbl_live[k] = 1'b0;
            own_addr_cfg = OWN_ADDR_RESET;
            expire_cfg = EXPIRE_RESET;
            retry_cfg = RETRY_LIMIT_RESET;
            due_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[PADDR_W-1:3])
                    REG_OWN_ADDR:    own_addr_cfg = pwdata[ADDR_W-1:0];
                    REG_EXPIRE_MS:   expire_cfg = pwdata[TIME_W-1:0];
                    REG_RETRY_LIMIT: retry_cfg = pwdata[RETRY_W-1:0];
                    default: ;
                endcase
            if (res.valid && res.ready)
            begin
                if (due_words.size() == 0)
                    report_mismatch("result word arrived with nothing outstanding");
                else
                begin
                    want = due_words.pop_front();
                    if (res.hit !== want.hit)
                        report_mismatch($sformatf("hit: expected %0d got %0d",
                                                  want.hit, res.hit));
                    if (res.slot !== want.slot)
                        report_mismatch($sformatf("slot: expected %0d got %0d",
                                                  want.slot, res.slot));
                    if (res.evicted !== want.evicted)
                        report_mismatch($sformatf("evicted: expected %0d got %0d",
                                                  want.evicted, res.evicted));
                    if (res.entry_id !== want.entry_id)
                        report_mismatch($sformatf("entry_id: expected %h got %h",
                                                  want.entry_id, res.entry_id));
                    if (res.expired_count !== want.expired_count)
                        report_mismatch($sformatf("expired_count: expected %0d got %0d",
                                                  want.expired_count, res.expired_count));
                    if (res.live_count !== want.live_count)
                        report_mismatch($sformatf("live_count: expected %0d got %0d",
                                                  want.live_count, res.live_count));
                    if (res.last !== want.last)
                        report_mismatch($sformatf("last: expected %0d got %0d",
                                                  want.last, res.last));
                end
            end
            if (cmd.valid && cmd.ready)
                predict_queue_op(op_t'(cmd.opcode), cmd.peer_addr, cmd.message_id,
                                 cmd.now_ms, cmd.send_ok);
        end
        words_due = due_words.size();
    end

endmodule

FILE: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfq_pkg::*;

    localparam int STALL_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * SFQ_QUEUE_DEPTH + 4;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatches;
    int words_due;
    int ops_accepted = 0;
    int ops_finished = 0;
    int idle_cycles = 0;
    int holds_asked = 0;
    bit steady = 1'b0;

    // stimulus-side view of the registers and traffic
    logic [ADDR_W-1:0] own_now;
    logic [TIME_W-1:0] expire_now;
    logic [TIME_W-1:0] ms_now;
    logic [TIME_W-1:0] last_store_ms;
    logic [ADDR_W-1:0] peers[4];
    logic [ID_W-1:0]   recent_ids[$];

    sfq_cmd_if cmd();
    sfq_res_if res();

    store_forward_queue_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfq_result_checker check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            ops_accepted <= ops_accepted + 1;
        if (res.valid && res.ready && res.last)
            ops_finished <= ops_finished + 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stretches of ready high and low, plus requested long holds
    initial
    begin : receiver
        int run_left;
        int holds_served;
        logic level;
        run_left = 0;
        holds_served = 0;
        level = 1'b0;
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_served)
            begin
                holds_served++;
                level = 1'b0;
                run_left = STALL_CYCLES;
            end
            else if (steady && run_left == 0)
            begin
                level = 1'b1;
                run_left = 1;
            end
            else if (run_left == 0)
            begin
                level = !level;
                if (level)
                    run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 20);
                else if ($urandom_range(0, 19) == 0)
                    run_left = $urandom_range(20, 60);
                else
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 8)
                                                            : $urandom_range(1, 2);
            end
            res.ready <= level;
            run_left--;
        end
    end

    function automatic int pick_gap();
        int dice;
        dice = $urandom_range(0, 99);
        if (steady || dice < 55)
            return 0;
        if (dice < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_op(input op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                           input logic ok);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= op;
        cmd.peer_addr  <= addr;
        cmd.message_id <= id;
        cmd.now_ms     <= now;
        cmd.send_ok    <= ok;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (op == OP_STORE)
        begin
            recent_ids = {recent_ids, id};
            if (recent_ids.size() > 12)
                void'(recent_ids.pop_front());
            last_store_ms = now;
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (ops_finished != ops_accepted);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic random_op(input int step_ms);
        int dice;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] now;
        logic ok;
        dice = $urandom_range(0, 99);
        ms_now = ms_now + $urandom_range(0, step_ms);
        addr = ($urandom_range(0, 9) < 8) ? peers[$urandom_range(0, 3)]
                                          : ADDR_W'({$urandom(), $urandom()});
        id = $urandom();
        now = ms_now;
        ok = ($urandom_range(0, 1) == 1);
        if (dice < 35)
        begin
            if ($urandom_range(0, 9) == 0)
                now = $urandom();
            send_op(OP_STORE, addr, id, now, ok);
        end
        else if (dice < 55)
        begin
            if ($urandom_range(0, 3) != 0)
                addr = own_now;
            if ($urandom_range(0, 3) != 0 && recent_ids.size() > 0)
                id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            send_op(OP_ACK, addr, id, now, ok);
        end
        else if (dice < 80)
        begin
            ok = ($urandom_range(0, 9) < 7);
            send_op(OP_DELIVER, addr, id, now, ok);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: now = $urandom();
                // right at the expiry edge of the newest entry
                1: now = last_store_ms + expire_now + $urandom_range(0, 1);
                default: now = ms_now;
            endcase
            send_op(OP_TICK, addr, id, now, ok);
        end
    endtask

    task automatic run_phase(input logic [ADDR_W-1:0] own, input logic [TIME_W-1:0] expire,
                             input logic [RETRY_W-1:0] retries, input int n_ops,
                             input int step_ms, input bit stall);
        cmd.valid <= 1'b0;
        wait_drained();
        write_reg(REG_OWN_ADDR, PDATA_W'(own));
        write_reg(REG_EXPIRE_MS, PDATA_W'(expire));
        write_reg(REG_RETRY_LIMIT, PDATA_W'(retries));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        own_now = own;
        expire_now = expire;
        if (stall)
            holds_asked <= holds_asked + 1;
        repeat (n_ops) random_op(step_ms);
    endtask

    initial
    begin : stimulus
        logic [ID_W-1:0] first_id;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd.valid = 1'b0;
        cmd.opcode = OP_STORE;
        cmd.peer_addr = '0;
        cmd.message_id = '0;
        cmd.now_ms = '0;
        cmd.send_ok = 1'b0;
        own_now = OWN_ADDR_RESET;
        expire_now = EXPIRE_RESET;
        ms_now = 32'd3000;
        last_store_ms = '0;
        peers[0] = '0;
        peers[1] = '1;
        peers[2] = ADDR_W'({$urandom(), $urandom()});
        peers[3] = ADDR_W'({$urandom(), $urandom()});
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset configuration
        send_op(OP_TICK, '0, '0, '0, 1'b0);
        send_op(OP_ACK, '0, 32'd5, '0, 1'b0);
        send_op(OP_DELIVER, '0, '0, '0, 1'b1);
        for (int k = 0; k < SFQ_QUEUE_DEPTH; k++)
        begin
            first_id = (k == 0) ? '0 : (k == 1) ? '1 : $urandom();
            // slots 1 and 2 tie on the oldest stamp
            send_op(OP_STORE, k[0] ? '1 : '0, first_id,
                    (k == 0) ? 32'd500 : (k < 3) ? 32'd100 :
                    (k == SFQ_QUEUE_DEPTH - 1) ? '1 : 32'(1000 + k), 1'b0);
        end
        send_op(OP_STORE, '1, $urandom(), 32'd2000, 1'b0);
        send_op(OP_STORE, '0, $urandom(), 32'd2001, 1'b0);
        send_op(OP_DELIVER, '0, '0, 32'd2002, 1'b0);
        repeat (3) send_op(OP_DELIVER, '1, '0, 32'd2003, 1'b1);
        send_op(OP_ACK, '0, '0, 32'd2004, 1'b0);
        send_op(OP_ACK, '1, '1, 32'd2005, 1'b0);
        send_op(OP_ACK, '0, '1, 32'd2006, 1'b0);
        send_op(OP_TICK, '0, '0, 32'd301004, 1'b0);
        send_op(OP_TICK, '0, '0, 32'd301005, 1'b0);
        send_op(OP_STORE, peers[2], $urandom(), 32'hFFFF_FF00, 1'b1);
        // age of the newest entry wraps to a small value
        send_op(OP_TICK, '0, '0, 32'h0000_0100, 1'b0);
        send_op(OP_TICK, '0, '0, '1, 1'b1);

        run_phase('1, 32'd1, 4'd1, 70, 3, 1'b0);
        run_phase(ADDR_W'({$urandom(), $urandom()}), '1, 4'd15, 70, 1000, 1'b1);
        ms_now = 32'hFFFF_0000;
        run_phase(ADDR_W'({$urandom(), $urandom()}), $urandom_range(50, 2000),
                  RETRY_W'($urandom_range(2, 5)), 90, 100, 1'b0);
        steady = 1'b1;
        run_phase('0, EXPIRE_RESET, RETRY_LIMIT_RESET, 90, 20000, 1'b0);
        steady = 1'b0;
        run_phase(ADDR_W'({$urandom(), $urandom()}), $urandom_range(1, 32'hFFFF_FFFF),
                  RETRY_W'($urandom_range(1, 15)), 80, 1 << 20, 1'b0);

        cmd.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && words_due == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
